@@ sv/iecm_pkg.sv @@
package iecm_pkg;

    // Fixed widths of the item and result fields.
    localparam int REQ_W       = 2;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int EVENT_W     = 7;
    localparam int CPU_LINES_W = 12;
    localparam int COMB_W      = 4;

    // Block size.
    localparam int NUM_GROUPS       = 4;
    localparam int NUM_CPU_INTS     = 12;
    localparam int EVENTS_PER_GROUP = 32;
    localparam int RESERVED_EVENTS  = 4;
    localparam int SEL_W            = 7;
    localparam int NUM_EVENTS       = EVENTS_PER_GROUP * NUM_GROUPS;
    localparam int EV_IDX_W         = $clog2(NUM_EVENTS);
    localparam int SEL_PER_WORD     = 4;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PULSE = 2'd2;

    // Register bank selected by address bits 3:2 while bit 4 is low.
    localparam logic [1:0] BANK_FLAGS  = 2'd0;
    localparam logic [1:0] BANK_CLEAR  = 2'd1;
    localparam logic [1:0] BANK_MASK   = 2'd2;
    localparam logic [1:0] BANK_MASKED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [ADDR_W-1:0]  reg_addr;
        logic [DATA_W-1:0]  write_data;
        logic [EVENT_W-1:0] event_num;
    } item_t;

    typedef logic [NUM_GROUPS-1:0][DATA_W-1:0] group_vec_t;
    typedef logic [NUM_CPU_INTS-1:0][SEL_W-1:0] sel_vec_t;

    typedef struct packed {
        group_vec_t flags;
        group_vec_t masks;
        sel_vec_t   route_sel;
    } state_t;

endpackage

@@ sv/iecm_req_if.sv @@
interface iecm_req_if;
    import iecm_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [ADDR_W-1:0]  reg_addr;
    logic [DATA_W-1:0]  write_data;
    logic [EVENT_W-1:0] event_num;

    modport source (output valid, output req_type, output reg_addr, output write_data,
                    output event_num, input ready);
    modport sink (input valid, input req_type, input reg_addr, input write_data,
                  input event_num, output ready);
endinterface

@@ sv/iecm_rsp_if.sv @@
interface iecm_rsp_if;
    import iecm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [DATA_W-1:0]      read_data;
    logic [CPU_LINES_W-1:0] cpu_int_lines;
    logic [COMB_W-1:0]      combined_lines;
    logic                   access_error;

    modport source (output valid, output read_data, output cpu_int_lines,
                    output combined_lines, output access_error, input ready);
    modport sink (input valid, input read_data, input cpu_int_lines,
                  input combined_lines, input access_error, output ready);
endinterface

@@ sv/iecm_regs.sv @@
module iecm_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        apply,
    input  iecm_pkg::item_t             item,
    output iecm_pkg::state_t            state_next,
    output logic [iecm_pkg::DATA_W-1:0] rd_data,
    output logic                        access_error
);
    import iecm_pkg::*;

    state_t     state_reg;
    logic [1:0] grp;
    logic [1:0] bank;
    logic [1:0] ev_grp;
    logic       is_wr;

    assign grp    = item.reg_addr[1:0];
    assign bank   = item.reg_addr[3:2];
    assign ev_grp = item.event_num[6:5];
    assign is_wr  = (item.req_type == REQ_WRITE);

    always_comb
    begin
        state_next   = state_reg;
        rd_data      = '0;
        access_error = 1'b0;
        if (item.req_type == REQ_READ || item.req_type == REQ_WRITE)
        begin
            if (!item.reg_addr[4])
            begin
                if (grp >= NUM_GROUPS)
                begin
                    access_error = 1'b1;
                end
                for (int i = 0; i < NUM_GROUPS; i++)
                begin
                    if (grp == 2'(i))
                    begin
                        case (bank)
                            BANK_FLAGS:
                            begin
                                if (!is_wr)
                                    rd_data = state_reg.flags[i];
                            end
                            BANK_CLEAR:
                            begin
                                if (is_wr)
                                    state_next.flags[i] = state_reg.flags[i] & ~item.write_data;
                            end
                            BANK_MASK:
                            begin
                                if (is_wr)
                                    state_next.masks[i] = item.write_data;
                                else
                                    rd_data = state_reg.masks[i];
                            end
                            BANK_MASKED:
                            begin
                                if (!is_wr)
                                    rd_data = state_reg.flags[i] & ~state_reg.masks[i];
                            end
                            default:
                            begin
                                rd_data = '0;
                            end
                        endcase
                    end
                end
            end
            else if (bank == 2'd0 && grp != 2'd3 && {grp, 2'b00} < NUM_CPU_INTS)
            begin
                // Mux word grp carries selectors 4*grp to 4*grp+3, one per byte.
                for (int k = 0; k < NUM_CPU_INTS; k++)
                begin
                    if (grp == 2'(k / SEL_PER_WORD))
                    begin
                        if (is_wr)
                            state_next.route_sel[k] =
                                item.write_data[8*(k % SEL_PER_WORD) +: SEL_W];
                        else
                            rd_data[8*(k % SEL_PER_WORD) +: SEL_W] = state_reg.route_sel[k];
                    end
                end
            end
            else
            begin
                access_error = 1'b1;
            end
        end
        else if (item.req_type == REQ_PULSE)
        begin
            if (item.event_num < RESERVED_EVENTS || ev_grp >= NUM_GROUPS)
            begin
                access_error = 1'b1;
            end
            else
            begin
                for (int i = 0; i < NUM_GROUPS; i++)
                begin
                    if (ev_grp == 2'(i))
                        state_next.flags[i][item.event_num[4:0]] = 1'b1;
                end
            end
        end
        else
        begin
            access_error = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (apply)
            state_reg <= state_next;
    end

endmodule

@@ sv/iecm_route.sv @@
module iecm_route (
    input  iecm_pkg::state_t                 state,
    output logic [iecm_pkg::CPU_LINES_W-1:0] cpu_int_lines,
    output logic [iecm_pkg::COMB_W-1:0]      combined_lines
);
    import iecm_pkg::*;

    logic [NUM_EVENTS-1:0] active;

    always_comb
    begin
        combined_lines = '0;
        for (int i = 0; i < NUM_GROUPS; i++)
            combined_lines[i] = |(state.flags[i] & ~state.masks[i]);
    end

    // Events 0 to 3 are the combined events; the rest follow their raw flag.
    always_comb
    begin
        for (int i = 0; i < NUM_GROUPS; i++)
            active[i*EVENTS_PER_GROUP +: EVENTS_PER_GROUP] = state.flags[i];
        active[RESERVED_EVENTS-1:0] = combined_lines[RESERVED_EVENTS-1:0];
    end

    always_comb
    begin
        cpu_int_lines = '0;
        for (int k = 0; k < NUM_CPU_INTS; k++)
            cpu_int_lines[k] = (state.route_sel[k] < NUM_EVENTS) &&
                               active[state.route_sel[k][EV_IDX_W-1:0]];
    end

endmodule

@@ sv/interrupt_event_combiner_mux.sv @@
// An accepted item passes through the input register and then the result
// register. Throughput: one item per cycle while the result register frees
// up; the state update, combining and selection all settle in the single
// stage between the input and result registers.
// Reset (rst_n, asynchronous, active low) clears all flags, masks and
// selectors and empties both pipeline registers.
module interrupt_event_combiner_mux (
    input  logic       clk,
    input  logic       rst_n,
    iecm_req_if.sink   req,
    iecm_rsp_if.source rsp
);
    import iecm_pkg::*;

    // Input register. It holds one item until the result register can take
    // the item's result.
    logic  s1_valid_reg;
    item_t s1_item_reg;

    // Result register.
    logic                   out_valid_reg;
    logic [DATA_W-1:0]      out_rd_reg;
    logic [CPU_LINES_W-1:0] out_lines_reg;
    logic [COMB_W-1:0]      out_comb_reg;
    logic                   out_err_reg;

    logic                   advance;
    logic                   s1_fire;
    state_t                 state_next;
    logic [DATA_W-1:0]      rd_data;
    logic                   access_error;
    logic [CPU_LINES_W-1:0] lines_next;
    logic [COMB_W-1:0]      comb_next;

    // The result register frees up when empty or when its item is taken, so
    // a new item enters every cycle that the output side keeps up.
    assign advance   = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;

    // The state commits only when the item moves into the result register,
    // so a stalled item is never applied twice.
    iecm_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .apply        (s1_fire),
        .item         (s1_item_reg),
        .state_next   (state_next),
        .rd_data      (rd_data),
        .access_error (access_error)
    );

    // The lines are formed from the state after this item has been applied.
    iecm_route u_route (
        .state          (state_next),
        .cpu_int_lines  (lines_next),
        .combined_lines (comb_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_item_reg.req_type   <= req.req_type;
            s1_item_reg.reg_addr   <= req.reg_addr;
            s1_item_reg.write_data <= req.write_data;
            s1_item_reg.event_num  <= req.event_num;
        end
        if (s1_fire)
        begin
            out_rd_reg    <= rd_data;
            out_lines_reg <= lines_next;
            out_comb_reg  <= comb_next;
            out_err_reg   <= access_error;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_data      = out_rd_reg;
    assign rsp.cpu_int_lines  = out_lines_reg;
    assign rsp.combined_lines = out_comb_reg;
    assign rsp.access_error   = out_err_reg;

endmodule

@@ tb/tb_interrupt_event_combiner_mux.sv @@
`timescale 1ns / 1ps

module tb_interrupt_event_combiner_mux;
    import iecm_pkg::*;

    // The package names three request codes; the fourth encoding is illegal
    // and must be flagged by the block.
    localparam logic [REQ_W-1:0] REQ_ILLEGAL = 2'd3;

    // Base addresses of the register banks and of the unmapped range.
    localparam logic [ADDR_W-1:0] ADDR_FLAGS    = 5'd0;
    localparam logic [ADDR_W-1:0] ADDR_CLEAR    = 5'd4;
    localparam logic [ADDR_W-1:0] ADDR_MASK     = 5'd8;
    localparam logic [ADDR_W-1:0] ADDR_MASKED   = 5'd12;
    localparam logic [ADDR_W-1:0] ADDR_MUX      = 5'd16;
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 5'd19;
    localparam logic [ADDR_W-1:0] ADDR_LAST     = 5'd31;

    // Cycles with no accepted item or status before the run is declared hung,
    // and the quiet time allowed after the last result (two-stage pipeline).
    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_CYCLES = 8;

    // One result item as the block reports it after applying an access.
    typedef struct packed {
        logic [DATA_W-1:0]      read_data;
        logic [CPU_LINES_W-1:0] cpu_int_lines;
        logic [COMB_W-1:0]      combined_lines;
        logic                   access_error;
    } irq_status_t;

    logic clk;
    logic rst_n;

    iecm_req_if req_ch ();
    iecm_rsp_if rsp_ch ();

    interrupt_event_combiner_mux dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Our own copy of the controller state, kept in step with accepted items.
    logic [DATA_W-1:0] flag_bank [NUM_GROUPS];
    logic [DATA_W-1:0] mask_bank [NUM_GROUPS];
    logic [SEL_W-1:0]  route_sel [NUM_CPU_INTS];

    // Status items predicted for accepted accesses, oldest first.
    irq_status_t pending_status [$];

    // Percentage of cycles in which the sender and the receiver hold off.
    int idle_pct;

    int fail_count;
    int checked_count;
    int read_count;
    int write_count;
    int pulse_count;
    int error_count;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Applies one access to the local state and returns the status the block
    // must report afterwards. Events 0 to 3 are the combined group events;
    // every other event follows its raw flag, whatever the mask says.
    function automatic irq_status_t apply_access(input item_t it);
        irq_status_t st;
        int          grp;
        int          word;
        int          sel_idx;
        int          ev_grp;
        logic        is_write;
        logic [SEL_W-1:0] sel;
        st = '0;
        grp = int'(it.reg_addr[1:0]);
        is_write = (it.req_type == REQ_WRITE);
        if (it.req_type == REQ_READ || it.req_type == REQ_WRITE)
        begin
            if (it.reg_addr < ADDR_MUX)
            begin
                if (grp >= NUM_GROUPS)
                begin
                    st.access_error = 1'b1;
                end
                else
                begin
                    case (it.reg_addr[3:2])
                        BANK_FLAGS:
                            if (!is_write) st.read_data = flag_bank[grp];
                        BANK_CLEAR:
                            if (is_write) flag_bank[grp] &= ~it.write_data;
                        BANK_MASK:
                            if (is_write) mask_bank[grp] = it.write_data;
                            else st.read_data = mask_bank[grp];
                        default:
                            if (!is_write) st.read_data = flag_bank[grp] & ~mask_bank[grp];
                    endcase
                end
            end
            else if (it.reg_addr < ADDR_UNMAPPED)
            begin
                word = int'(it.reg_addr - ADDR_MUX);
                if (word * SEL_PER_WORD >= NUM_CPU_INTS)
                begin
                    st.access_error = 1'b1;
                end
                else
                begin
                    for (int j = 0; j < SEL_PER_WORD; j++)
                    begin
                        sel_idx = word * SEL_PER_WORD + j;
                        if (sel_idx < NUM_CPU_INTS)
                        begin
                            if (is_write)
                                route_sel[sel_idx] = it.write_data[8*j +: SEL_W];
                            else
                                st.read_data |= DATA_W'(route_sel[sel_idx]) << (8 * j);
                        end
                    end
                end
            end
            else
            begin
                st.access_error = 1'b1;
            end
        end
        else if (it.req_type == REQ_PULSE)
        begin
            ev_grp = int'(it.event_num) / EVENTS_PER_GROUP;
            if (it.event_num < RESERVED_EVENTS || ev_grp >= NUM_GROUPS)
                st.access_error = 1'b1;
            else
                flag_bank[ev_grp][it.event_num % EVENTS_PER_GROUP] = 1'b1;
        end
        else
        begin
            st.access_error = 1'b1;
        end

        for (int g = 0; g < NUM_GROUPS; g++)
            st.combined_lines[g] = |(flag_bank[g] & ~mask_bank[g]);

        for (int k = 0; k < NUM_CPU_INTS; k++)
        begin
            sel = route_sel[k];
            ev_grp = int'(sel) / EVENTS_PER_GROUP;
            if (ev_grp < NUM_GROUPS)
            begin
                if (sel < RESERVED_EVENTS)
                    st.cpu_int_lines[k] = st.combined_lines[sel];
                else
                    st.cpu_int_lines[k] = flag_bank[ev_grp][sel % EVENTS_PER_GROUP];
            end
        end
        return st;
    endfunction

    function automatic item_t make_access(input logic [REQ_W-1:0] rq,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [DATA_W-1:0] data,
                                          input logic [EVENT_W-1:0] ev);
        item_t it;
        it.req_type = rq;
        it.reg_addr = addr;
        it.write_data = data;
        it.event_num = ev;
        return it;
    endfunction

    // Random traffic. Pulses dominate so that flags fill up and the routed
    // lines see activity; clears and mask writes then pull them back down.
    // A small share goes to unmapped addresses, reserved events and the
    // illegal request code. Fields that the request ignores stay random.
    function automatic item_t random_access();
        item_t it;
        int    pick;
        int    shape;
        it.req_type = REQ_ILLEGAL;
        it.reg_addr = ADDR_W'($urandom_range(ADDR_UNMAPPED - 1));
        it.write_data = $urandom;
        it.event_num = EVENT_W'($urandom_range(RESERVED_EVENTS, NUM_EVENTS - 1));
        pick = $urandom_range(99);
        if ($urandom_range(99) < 10)
            it.reg_addr = ADDR_W'($urandom_range(ADDR_UNMAPPED, ADDR_LAST));
        if (pick < 40)
        begin
            it.req_type = REQ_PULSE;
            if ($urandom_range(99) < 5)
                it.event_num = EVENT_W'($urandom_range(RESERVED_EVENTS - 1));
        end
        else if (pick < 70)
        begin
            it.req_type = REQ_READ;
        end
        else if (pick < 97)
        begin
            it.req_type = REQ_WRITE;
            shape = $urandom_range(9);
            if (shape == 0)
                it.write_data = '0;
            else if (shape == 1)
                it.write_data = '1;
            else if (shape < 5)
                it.write_data = $urandom & $urandom;
        end
        return it;
    endfunction

    // Offers one item at the falling edge, with random hold-offs before it,
    // and returns at the rising edge where it was taken.
    task automatic send_access(input item_t it);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= it.req_type;
        req_ch.reg_addr   <= it.reg_addr;
        req_ch.write_data <= it.write_data;
        req_ch.event_num  <= it.event_num;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    // Stops offering items and waits until every predicted status has come.
    task automatic wait_for_drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_access(make_access(REQ_READ, ADDR_FLAGS, '0, '0));
        send_access(make_access(REQ_READ, ADDR_MASK + 5'd3, '1, '1));
        send_access(make_access(REQ_READ, ADDR_MASKED + 5'd3, '0, '0));
        send_access(make_access(REQ_READ, ADDR_MUX + 5'd2, '0, '0));
    endtask

    // The lowest and highest ordinary events, one in the middle, and the
    // reserved combined-event numbers, which must be refused.
    task automatic test_event_pulses();
        send_access(make_access(REQ_PULSE, ADDR_FLAGS, '0, 7'd4));
        send_access(make_access(REQ_PULSE, ADDR_FLAGS, '0, 7'd127));
        send_access(make_access(REQ_PULSE, ADDR_FLAGS, '0, 7'd40));
        send_access(make_access(REQ_PULSE, ADDR_FLAGS, '1, 7'd0));
        send_access(make_access(REQ_PULSE, ADDR_FLAGS, '1, 7'd3));
    endtask

    // Selector 0 takes event 4, selector 1 an idle event, selector 2 event
    // 127 and selector 3 combined event 0. The all-ones write to the last
    // word checks that the eighth bit of each byte is dropped.
    task automatic test_routing();
        send_access(make_access(REQ_WRITE, ADDR_MUX, 32'h007F_0504, '0));
        send_access(make_access(REQ_READ, ADDR_MUX, '0, '0));
        send_access(make_access(REQ_WRITE, ADDR_MUX + 5'd2, '1, '0));
        send_access(make_access(REQ_READ, ADDR_MUX + 5'd2, '0, '0));
    endtask

    // Masking all of group 0 drops combined event 0 while event 4 stays
    // routed. Writes to the read-only flag views must be ignored silently,
    // and the clear register always reads back as zero.
    task automatic test_clear_and_mask();
        send_access(make_access(REQ_WRITE, ADDR_MASK, '1, '0));
        send_access(make_access(REQ_READ, ADDR_MASKED, '0, '0));
        send_access(make_access(REQ_WRITE, ADDR_FLAGS, '1, '0));
        send_access(make_access(REQ_WRITE, ADDR_MASKED, '1, '0));
        send_access(make_access(REQ_READ, ADDR_CLEAR, '0, '0));
        send_access(make_access(REQ_WRITE, ADDR_CLEAR + 5'd3, '1, '0));
        send_access(make_access(REQ_READ, ADDR_FLAGS + 5'd3, '0, '0));
    endtask

    task automatic test_access_errors();
        send_access(make_access(REQ_READ, ADDR_UNMAPPED, '0, '0));
        send_access(make_access(REQ_WRITE, ADDR_LAST, '1, '1));
        send_access(make_access(REQ_ILLEGAL, ADDR_FLAGS, '1, 7'd5));
    endtask

    task automatic test_random_traffic(input int count, input int pct);
        idle_pct = pct;
        repeat (count)
            send_access(random_access());
    endtask

    task automatic compare_status(input irq_status_t exp, input irq_status_t got);
        if (got.read_data !== exp.read_data)
        begin
            $error("read_data: expected %h, got %h", exp.read_data, got.read_data);
            fail_count++;
        end
        if (got.cpu_int_lines !== exp.cpu_int_lines)
        begin
            $error("cpu_int_lines: expected %h, got %h",
                   exp.cpu_int_lines, got.cpu_int_lines);
            fail_count++;
        end
        if (got.combined_lines !== exp.combined_lines)
        begin
            $error("combined_lines: expected %h, got %h",
                   exp.combined_lines, got.combined_lines);
            fail_count++;
        end
        if (got.access_error !== exp.access_error)
        begin
            $error("access_error: expected %b, got %b",
                   exp.access_error, got.access_error);
            fail_count++;
        end
    endtask

    // The receiver drops ready at random falling edges, at the same rate as
    // the sender idles.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Everything is observed at the rising edge, before the block's own
    // registers update. An accepted access is applied to the local state
    // right away; an accepted status is compared with the oldest prediction.
    // The same process runs the watchdog on handshake activity.
    always @(posedge clk)
    begin
        irq_status_t got;
        irq_status_t exp;
        item_t       it;
        logic        moved;
        moved = 1'b0;
        if (rst_n && req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
        begin
            it = make_access(req_ch.req_type, req_ch.reg_addr,
                             req_ch.write_data, req_ch.event_num);
            exp = apply_access(it);
            pending_status.push_back(exp);
            case (it.req_type)
                REQ_READ:  read_count++;
                REQ_WRITE: write_count++;
                REQ_PULSE: pulse_count++;
                default:   ;
            endcase
            if (exp.access_error)
                error_count++;
            moved = 1'b1;
        end
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got.read_data      = rsp_ch.read_data;
            got.cpu_int_lines  = rsp_ch.cpu_int_lines;
            got.combined_lines = rsp_ch.combined_lines;
            got.access_error   = rsp_ch.access_error;
            if (pending_status.size() == 0)
            begin
                $error("status item arrived with no access waiting for one");
                fail_count++;
            end
            else
            begin
                exp = pending_status.pop_front();
                compare_status(exp, got);
                checked_count++;
            end
            moved = 1'b1;
        end
        if (moved)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Stalled for %0d cycles with %0d status items outstanding.",
                     quiet_cycles, pending_status.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Test sequence: directed checks of each register and special case, then
    // three random phases. The first and last idle at random; the middle one
    // runs at full rate on both sides. Before it the sender holds back until
    // every outstanding status has come back.
    initial
    begin
        fail_count    = 0;
        checked_count = 0;
        read_count    = 0;
        write_count   = 0;
        pulse_count   = 0;
        error_count   = 0;
        quiet_cycles  = 0;
        idle_pct      = 12;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            flag_bank[g] = '0;
            mask_bank[g] = '0;
        end
        for (int k = 0; k < NUM_CPU_INTS; k++)
            route_sel[k] = '0;

        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_READ;
        req_ch.reg_addr   = '0;
        req_ch.write_data = '0;
        req_ch.event_num  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_event_pulses();
        test_routing();
        test_clear_and_mask();
        test_access_errors();

        test_random_traffic(600, 12);
        wait_for_drain();
        test_random_traffic(500, 0);
        test_random_traffic(527, 12);

        // Let the pipeline empty, then give it a few quiet cycles so that a
        // spurious extra status item would still be caught.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d status items: %0d reads, %0d writes, %0d event pulses, %0d errors.",
                 checked_count, read_count, write_count, pulse_count, error_count);
        $display("Traffic covered all register banks, routing words and bad accesses, with and without stalls.");
        if (fail_count == 0 && pending_status.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
